FILE: src/rsmp_pkg.sv
// ----------------------------------------------------------------------------
// rsmp_pkg
// Shared types and constants of the 147/160 polyphase resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package rsmp_pkg;

    localparam int UP_FACTOR   = 147;
    localparam int DOWN_FACTOR = 160;
    localparam int STEP_INT    = DOWN_FACTOR / UP_FACTOR;
    localparam int STEP_FRAC   = DOWN_FACTOR % UP_FACTOR;

    localparam int COEF_WIDTH  = 24;
    localparam int FRAC_BITS   = COEF_WIDTH - 2;
    localparam int SAMPLE_W    = 16;
    localparam int PAIR_W      = 2 * SAMPLE_W;
    localparam int HALF_W      = 15;
    localparam int IDX_W       = 32;
    localparam int PH_W        = 9;
    localparam int QUOT_W      = 8;
    localparam int TAP_CNT_W   = 10;
    localparam int DIST_W      = 18;
    localparam int ACC_W       = COEF_WIDTH + SAMPLE_W + TAP_CNT_W;

    localparam int SAT_MAX     = 32767;
    localparam int SAT_MIN     = -32768;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;

    localparam logic OP_COEF   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef logic signed [SAMPLE_W-1:0]   t_sample;
    typedef logic signed [COEF_WIDTH-1:0] t_coef;

    typedef struct packed {
        logic clr;
        logic tap;
        logic fin;
    } t_mac_ctl;

endpackage

`default_nettype wire

FILE: src/rsmp_coef_mem.sv
// ----------------------------------------------------------------------------
// rsmp_coef_mem
// Half table of filter coefficients, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rsmp_coef_mem #(
    parameter  int COEF_DEPTH = 32768,
    localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [COEF_AW-1:0]   i_wr_addr,
    input  wire rsmp_pkg::t_coef      i_wr_data,
    input  wire logic                 i_rd_en,
    input  wire logic [COEF_AW-1:0]   i_rd_addr,
    input  wire logic                 i_rd_zero,
    output rsmp_pkg::t_coef           o_rd_data
);

    rsmp_pkg::t_coef r_mem [0:COEF_DEPTH-1];
    rsmp_pkg::t_coef r_rd_data;
    logic            r_rd_zero;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_zero <= i_rd_zero;
        end
    end

    assign o_rd_data = r_rd_zero ? '0 : r_rd_data;

endmodule

`default_nettype wire

FILE: src/rsmp_hist_mem.sv
// ----------------------------------------------------------------------------
// rsmp_hist_mem
// Circular stereo sample history with a fill count; unwritten slots read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rsmp_hist_mem #(
    parameter  int HISTORY_DEPTH = 512,
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH),
    localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clear,
    input  wire logic                          i_wr_en,
    input  wire logic [rsmp_pkg::PAIR_W-1:0]   i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [SLOT_W-1:0]             i_rd_addr,
    output logic      [SLOT_W-1:0]             o_wr_slot,
    output logic      [rsmp_pkg::PAIR_W-1:0]   o_rd_data
);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);

    logic [rsmp_pkg::PAIR_W-1:0] r_mem [0:HISTORY_DEPTH-1];
    logic [rsmp_pkg::PAIR_W-1:0] r_rd_data;
    logic                        r_rd_zero;
    logic [SLOT_W-1:0]           r_wr_slot;
    logic [FILL_W-1:0]           r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wr_slot <= '0;
            r_fill    <= '0;
        end else if (i_wr_en) begin
            r_wr_slot <= (r_wr_slot == SLOT_LAST) ? '0 : r_wr_slot + 1'b1;
            if (r_fill != FILL_FULL) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_slot] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_zero <= FILL_W'(i_rd_addr) >= r_fill;
        end
    end

    assign o_wr_slot = r_wr_slot;
    assign o_rd_data = r_rd_zero ? '0 : r_rd_data;

endmodule

`default_nettype wire

FILE: src/rsmp_mac.sv
// ----------------------------------------------------------------------------
// rsmp_mac
// Two-lane multiply-accumulate with half-even rounding and 16-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module rsmp_mac (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire rsmp_pkg::t_mac_ctl           i_ctl,
    input  wire rsmp_pkg::t_coef              i_coef,
    input  wire logic [rsmp_pkg::PAIR_W-1:0]  i_hist,
    output logic                              o_busy,
    output rsmp_pkg::t_sample                 o_left,
    output rsmp_pkg::t_sample                 o_right
);

    localparam int PROD_W = rsmp_pkg::COEF_WIDTH + rsmp_pkg::SAMPLE_W;
    localparam int ACC_W  = rsmp_pkg::ACC_W;
    localparam int FRAC   = rsmp_pkg::FRAC_BITS;
    localparam int Q_W    = ACC_W - FRAC + 1;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(rsmp_pkg::SAT_MAX);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(rsmp_pkg::SAT_MIN);

    function automatic rsmp_pkg::t_sample round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [Q_W-1:0] q;
        logic [FRAC-1:0]       rem;
        logic                  up;
        q   = {acc[ACC_W-1], acc[ACC_W-1:FRAC]};
        rem = acc[FRAC-1:0];
        up  = rem[FRAC-1] && ((rem[FRAC-2:0] != '0) || q[0]);
        q   = q + {{(Q_W-1){1'b0}}, up};
        if (q > Q_MAX) begin
            q = Q_MAX;
        end else if (q < Q_MIN) begin
            q = Q_MIN;
        end
        return q[rsmp_pkg::SAMPLE_W-1:0];
    endfunction

    rsmp_pkg::t_sample          hist_l;
    rsmp_pkg::t_sample          hist_r;
    logic signed [PROD_W-1:0]   r_prod_l;
    logic signed [PROD_W-1:0]   r_prod_r;
    logic                       r_pv;
    logic signed [ACC_W-1:0]    r_acc_l;
    logic signed [ACC_W-1:0]    r_acc_r;
    rsmp_pkg::t_sample          r_left;
    rsmp_pkg::t_sample          r_right;

    assign hist_l = i_hist[rsmp_pkg::SAMPLE_W-1:0];
    assign hist_r = i_hist[rsmp_pkg::PAIR_W-1:rsmp_pkg::SAMPLE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.tap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.tap) begin
            r_prod_l <= i_coef * hist_l;
            r_prod_r <= i_coef * hist_r;
        end
        if (i_ctl.clr) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_pv) begin
            r_acc_l <= r_acc_l + ACC_W'(r_prod_l);
            r_acc_r <= r_acc_r + ACC_W'(r_prod_r);
        end
        if (i_ctl.fin) begin
            r_left  <= round_sat(r_acc_l);
            r_right <= round_sat(r_acc_r);
        end
    end

    assign o_busy  = r_pv;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

`default_nettype wire

FILE: src/polyphase_resampler_48k_to_44k1_unit.sv
// ----------------------------------------------------------------------------
// polyphase_resampler_48k_to_44k1_unit
// Stereo 147/160 polyphase FIR rate converter with a loadable symmetric
// coefficient half table and a running output peak.
//
//  channel   direction  handshake                      payload
//  cfg       in         i_cfg_valid / o_cfg_ready      half_order
//  s_axis    in         s_axis_tvalid / s_axis_tready  op (tuser), coef/sample
//  m_axis    out        m_axis_tvalid / m_axis_tready  left, right, peak
//
// Coefficient item: written in S_IDLE; the next item can follow it. Sample
// item: S_CHK, then if an output is due S_MOD (history offset), S_TAP (one
// tap per cycle of the shared multiply-accumulate unit, taps up to 446),
// S_DRAIN and S_PUT. half_order write: busy in S_CFG to load the window.
// Reset and half_order writes restart the history through a fill count; no
// clearing pass. One result waits in the output register while the next item
// is taken; a second result holds the sequencer until the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module polyphase_resampler_48k_to_44k1_unit #(
    parameter int HISTORY_DEPTH = 512,
    parameter int COEF_DEPTH    = 32768
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [rsmp_pkg::HALF_W-1:0]         i_cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // coef_index[14:0], coef_value[38:15], left_in[54:39], right_in[70:55]
    input  wire logic [rsmp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // op[0]
    input  wire logic [0:0]                          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // left_out[15:0], right_out[31:16], peak_level[47:32]
    output logic      [rsmp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
    localparam int COEF_AW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int IDX_W   = rsmp_pkg::IDX_W;
    localparam int DIST_W  = rsmp_pkg::DIST_W;
    localparam int PH_W    = rsmp_pkg::PH_W;
    localparam int QUOT_W  = rsmp_pkg::QUOT_W;
    localparam int CNT_W   = rsmp_pkg::TAP_CNT_W;
    localparam int HALF_W  = rsmp_pkg::HALF_W;
    localparam int SW      = rsmp_pkg::SAMPLE_W;

    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [SLOT_W:0]   HIST_LIM   = (SLOT_W + 1)'(HISTORY_DEPTH);
    localparam logic [IDX_W-1:0]  DEPTH_IDX  = IDX_W'(HISTORY_DEPTH);
    localparam logic [DIST_W-1:0] COEF_LIM   = DIST_W'(COEF_DEPTH);
    localparam logic [HALF_W+1:0] COEF_LIM_W = (HALF_W + 2)'(COEF_DEPTH);
    localparam logic [HALF_W-1:0] UP_H       = HALF_W'(rsmp_pkg::UP_FACTOR);
    localparam logic [PH_W-1:0]   UP_PH      = PH_W'(rsmp_pkg::UP_FACTOR);
    localparam logic [PH_W-1:0]   FRAC_PH    = PH_W'(rsmp_pkg::STEP_FRAC);
    localparam logic [IDX_W-1:0]  STEP_LO    = IDX_W'(rsmp_pkg::STEP_INT);
    localparam logic [IDX_W-1:0]  STEP_HI    = IDX_W'(rsmp_pkg::STEP_INT + 1);
    localparam logic [DIST_W-1:0] UP_DIST    = DIST_W'(rsmp_pkg::UP_FACTOR);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CFG,
        S_CHK,
        S_MOD,
        S_TAP,
        S_DRAIN,
        S_PUT
    } t_state;

    t_state                     r_state;
    logic [HALF_W-1:0]          r_half;
    logic [HALF_W-1:0]          r_div_rem;
    logic [QUOT_W-1:0]          r_div_q;
    logic [IDX_W-1:0]           r_sr;
    logic [IDX_W-1:0]           r_ws_idx;
    logic signed [PH_W-1:0]     r_ws_ph;
    logic [IDX_W-1:0]           r_we_idx;
    logic [PH_W-2:0]            r_we_ph;
    logic [IDX_W-1:0]           r_back;
    logic [CNT_W-1:0]           r_cnt;
    logic signed [DIST_W-1:0]   r_dist;
    logic [SLOT_W-1:0]          r_slot;
    logic                       r_tap_d1;
    logic [SW-1:0]              r_peak;
    logic                       r_m_valid;
    rsmp_pkg::t_sample          r_out_l;
    rsmp_pkg::t_sample          r_out_r;

    logic                       in_op;
    logic [HALF_W-1:0]          in_coef_index;
    rsmp_pkg::t_coef            in_coef_value;
    rsmp_pkg::t_sample          in_left;
    rsmp_pkg::t_sample          in_right;
    logic                       s_acc;
    logic                       cfg_acc;
    logic                       coef_wr;
    logic                       hist_wr;
    logic [IDX_W-1:0]           due_diff;
    logic                       due;
    logic [DIST_W-1:0]          dist_abs;
    logic                       coef_zero;
    logic [SLOT_W:0]            slot_diff;
    logic [SLOT_W-1:0]          slot0;
    logic [SLOT_W-1:0]          wr_slot;
    logic [rsmp_pkg::PAIR_W-1:0] hist_q;
    rsmp_pkg::t_coef            coef_q;
    rsmp_pkg::t_mac_ctl         mac_ctl;
    logic                       mac_busy;
    rsmp_pkg::t_sample          mac_l;
    rsmp_pkg::t_sample          mac_r;
    logic [SW-1:0]              abs_l;
    logic [SW-1:0]              abs_r;
    logic [SW-1:0]              n_peak;
    logic signed [PH_W-1:0]     ws_sum;
    logic [PH_W-1:0]            we_sum;
    logic signed [PH_W-1:0]     n_ws_ph;
    logic [IDX_W-1:0]           n_ws_idx;
    logic [PH_W-2:0]            n_we_ph;
    logic [IDX_W-1:0]           n_we_idx;

    assign in_op         = s_axis_tuser[0];
    assign in_coef_index = s_axis_tdata[14:0];
    assign in_coef_value = s_axis_tdata[38:15];
    assign in_left       = s_axis_tdata[54:39];
    assign in_right      = s_axis_tdata[70:55];

    assign o_cfg_ready   = (r_state == S_IDLE);
    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign coef_wr       = s_acc && (in_op == rsmp_pkg::OP_COEF)
                           && ({2'b00, in_coef_index} < COEF_LIM_W);
    assign hist_wr       = s_acc && (in_op == rsmp_pkg::OP_SAMPLE);

    assign due_diff  = r_sr - r_we_idx;
    assign due       = (due_diff != '0) && !due_diff[IDX_W-1];

    assign dist_abs  = r_dist[DIST_W-1] ? DIST_W'(-r_dist) : DIST_W'(r_dist);
    assign coef_zero = dist_abs >= COEF_LIM;

    assign slot_diff = {1'b0, wr_slot} - {1'b0, r_back[SLOT_W-1:0]};
    assign slot0     = slot_diff[SLOT_W] ? SLOT_W'(slot_diff + HIST_LIM)
                                         : slot_diff[SLOT_W-1:0];

    assign mac_ctl.clr = (r_state == S_CHK);
    assign mac_ctl.tap = r_tap_d1;
    assign mac_ctl.fin = (r_state == S_DRAIN) && !r_tap_d1 && !mac_busy;

    assign abs_l  = mac_l[SW-1] ? SW'(-mac_l) : SW'(mac_l);
    assign abs_r  = mac_r[SW-1] ? SW'(-mac_r) : SW'(mac_r);

    always_comb begin
        n_peak = r_peak;
        if (abs_l > n_peak) begin
            n_peak = abs_l;
        end
        if (abs_r > n_peak) begin
            n_peak = abs_r;
        end
    end

    always_comb begin
        ws_sum = r_ws_ph + FRAC_PH;
        if (ws_sum > 0) begin
            n_ws_ph  = ws_sum - UP_PH;
            n_ws_idx = r_ws_idx + STEP_HI;
        end else begin
            n_ws_ph  = ws_sum;
            n_ws_idx = r_ws_idx + STEP_LO;
        end
        we_sum = {1'b0, r_we_ph} + FRAC_PH;
        if (we_sum >= UP_PH) begin
            n_we_ph  = (PH_W - 1)'(we_sum - UP_PH);
            n_we_idx = r_we_idx + STEP_HI;
        end else begin
            n_we_ph  = we_sum[PH_W-2:0];
            n_we_idx = r_we_idx + STEP_LO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_half    <= '0;
            r_sr      <= '0;
            r_ws_idx  <= '0;
            r_ws_ph   <= '0;
            r_we_idx  <= '0;
            r_we_ph   <= '0;
            r_tap_d1  <= 1'b0;
            r_peak    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_tap_d1 <= (r_state == S_TAP);
            if (r_m_valid && m_axis_tready && (r_state != S_PUT)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cfg_acc) begin
                        r_half    <= i_cfg_data;
                        r_div_rem <= i_cfg_data;
                        r_div_q   <= '0;
                        r_sr      <= '0;
                        r_state   <= S_CFG;
                    end else if (hist_wr) begin
                        r_sr    <= r_sr + 1'b1;
                        r_state <= S_CHK;
                    end
                end
                S_CFG: begin
                    if (r_div_rem >= UP_H) begin
                        r_div_rem <= r_div_rem - UP_H;
                        r_div_q   <= r_div_q + 1'b1;
                    end else begin
                        r_ws_idx <= '0 - IDX_W'(r_div_q);
                        r_ws_ph  <= '0 - PH_W'(r_div_rem[PH_W-2:0]);
                        r_we_idx <= IDX_W'(r_div_q);
                        r_we_ph  <= r_div_rem[PH_W-2:0];
                        r_state  <= S_IDLE;
                    end
                end
                S_CHK: begin
                    if (due) begin
                        r_back  <= r_sr - r_ws_idx;
                        r_cnt   <= CNT_W'(r_we_idx - r_ws_idx + 1'b1);
                        r_dist  <= '0 - DIST_W'(r_half) - DIST_W'(r_ws_ph);
                        r_state <= S_MOD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MOD: begin
                    if (r_back >= DEPTH_IDX) begin
                        r_back <= r_back - DEPTH_IDX;
                    end else begin
                        r_slot  <= slot0;
                        r_state <= (r_cnt == '0) ? S_DRAIN : S_TAP;
                    end
                end
                S_TAP: begin
                    r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                    r_dist <= r_dist + UP_DIST;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (mac_ctl.fin) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_out_l   <= mac_l;
                        r_out_r   <= mac_r;
                        r_peak    <= n_peak;
                        r_m_valid <= 1'b1;
                        r_ws_idx  <= n_ws_idx;
                        r_ws_ph   <= n_ws_ph;
                        r_we_idx  <= n_we_idx;
                        r_we_ph   <= n_we_ph;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    rsmp_hist_mem #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (cfg_acc),
        .i_wr_en   (hist_wr),
        .i_wr_data ({in_right, in_left}),
        .i_rd_en   (r_state == S_TAP),
        .i_rd_addr (r_slot),
        .o_wr_slot (wr_slot),
        .o_rd_data (hist_q)
    );

    rsmp_coef_mem #(
        .COEF_DEPTH (COEF_DEPTH)
    ) u_coef (
        .i_clk     (i_clk),
        .i_wr_en   (coef_wr),
        .i_wr_addr (COEF_AW'(in_coef_index)),
        .i_wr_data (in_coef_value),
        .i_rd_en   (r_state == S_TAP),
        .i_rd_addr (dist_abs[COEF_AW-1:0]),
        .i_rd_zero (coef_zero),
        .o_rd_data (coef_q)
    );

    rsmp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_coef  (coef_q),
        .i_hist  (hist_q),
        .o_busy  (mac_busy),
        .o_left  (mac_l),
        .o_right (mac_r)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_peak, r_out_r, r_out_l};

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 147/160 stereo polyphase resampler. Loads
// coefficient tables, sweeps half_order over the loaded table range and
// streams sample pairs under random sender bursts and receiver stalls. Every
// output item is compared field by field against an in-bench filter model.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH    = 512;
    localparam int COEF_DEPTH    = 32768;
    localparam int TABLE_LO      = 320;
    localparam int PHASE_ITEMS   = 88;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 2000;
    localparam int DRAIN_LIMIT   = 200000;

    typedef struct packed {
        logic signed [rsmp_pkg::SAMPLE_W-1:0] left;
        logic signed [rsmp_pkg::SAMPLE_W-1:0] right;
        logic        [rsmp_pkg::SAMPLE_W-1:0] peak;
    } t_stereo_out;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [rsmp_pkg::HALF_W-1:0]         i_cfg_data = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // coef_index, coef_value, left_in, right_in, pad
    logic [rsmp_pkg::IN_TDATA_W-1:0]     s_axis_tdata = '0;
    // op
    logic [0:0]                          s_axis_tuser = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // left_out, right_out, peak_level
    logic [rsmp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;

    polyphase_resampler_48k_to_44k1_unit #(
        .HISTORY_DEPTH(HIST_DEPTH),
        .COEF_DEPTH   (COEF_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("testbench: errors");
        $finish;
    end

    // filter state
    int unsigned                    order_cfg = 0;
    rsmp_pkg::t_sample              hist_l [HIST_DEPTH];
    rsmp_pkg::t_sample              hist_r [HIST_DEPTH];
    rsmp_pkg::t_coef                coef_mem [COEF_DEPTH];
    int unsigned                    n_received;
    int unsigned                    wr_slot;
    int unsigned                    lo_idx;
    int                             lo_ph;
    int unsigned                    hi_idx;
    int                             hi_ph;
    logic [rsmp_pkg::SAMPLE_W-1:0]  peak_mag = '0;

    t_stereo_out expected_pairs [$];
    int          fail_count = 0;

    function automatic void restart_stream();
        foreach (hist_l[i]) begin
            hist_l[i] = '0;
            hist_r[i] = '0;
        end
        n_received = 0;
        wr_slot    = 0;
        lo_idx     = 0 - order_cfg / rsmp_pkg::UP_FACTOR;
        lo_ph      = -int'(order_cfg % rsmp_pkg::UP_FACTOR);
        hi_idx     = order_cfg / rsmp_pkg::UP_FACTOR;
        hi_ph      = int'(order_cfg % rsmp_pkg::UP_FACTOR);
    endfunction

    function automatic rsmp_pkg::t_sample round_half_even(input longint acc);
        longint                         q;
        logic [rsmp_pkg::FRAC_BITS-1:0] rem;
        q   = acc >>> rsmp_pkg::FRAC_BITS;
        rem = acc[rsmp_pkg::FRAC_BITS-1:0];
        if (rem > (1 << (rsmp_pkg::FRAC_BITS - 1))
            || (rem == (1 << (rsmp_pkg::FRAC_BITS - 1)) && q[0])) begin
            q++;
        end
        if (q > rsmp_pkg::SAT_MAX) begin
            return rsmp_pkg::t_sample'(rsmp_pkg::SAT_MAX);
        end
        if (q < rsmp_pkg::SAT_MIN) begin
            return rsmp_pkg::t_sample'(rsmp_pkg::SAT_MIN);
        end
        return rsmp_pkg::t_sample'(q);
    endfunction

    function automatic logic [rsmp_pkg::SAMPLE_W-1:0] magnitude(input rsmp_pkg::t_sample v);
        return (v < 0) ? rsmp_pkg::SAMPLE_W'(-int'(v)) : rsmp_pkg::SAMPLE_W'(v);
    endfunction

    function automatic bit resample_pair(input rsmp_pkg::t_sample l,
                                         input rsmp_pkg::t_sample r,
                                         output t_stereo_out res);
        int unsigned       due;
        int unsigned       taps;
        int unsigned       idx;
        int unsigned       back;
        int unsigned       slot;
        longint            tap_dist;
        longint            mag;
        longint            c;
        longint            acc_l;
        longint            acc_r;
        rsmp_pkg::t_sample out_l;
        rsmp_pkg::t_sample out_r;
        hist_l[wr_slot] = l;
        hist_r[wr_slot] = r;
        wr_slot = (wr_slot + 1) % HIST_DEPTH;
        n_received++;
        due = n_received - hi_idx;
        if (due == 0 || due[31]) begin
            return 1'b0;
        end
        taps     = hi_idx - lo_idx + 1;
        tap_dist = -longint'(order_cfg) - lo_ph;
        idx      = lo_idx;
        acc_l    = 0;
        acc_r    = 0;
        for (int unsigned k = 0; k < taps; k++) begin
            back     = (n_received - idx) % HIST_DEPTH;
            slot     = (wr_slot + HIST_DEPTH - back) % HIST_DEPTH;
            mag      = (tap_dist < 0) ? -tap_dist : tap_dist;
            c        = (mag < COEF_DEPTH) ? longint'(coef_mem[mag]) : 0;
            acc_l    += c * longint'(hist_l[slot]);
            acc_r    += c * longint'(hist_r[slot]);
            tap_dist += rsmp_pkg::UP_FACTOR;
            idx++;
        end
        out_l = round_half_even(acc_l);
        out_r = round_half_even(acc_r);
        if (magnitude(out_l) > peak_mag) begin
            peak_mag = magnitude(out_l);
        end
        if (magnitude(out_r) > peak_mag) begin
            peak_mag = magnitude(out_r);
        end
        res.left  = out_l;
        res.right = out_r;
        res.peak  = peak_mag;
        lo_idx += rsmp_pkg::STEP_INT;
        lo_ph  += rsmp_pkg::STEP_FRAC;
        if (lo_ph > 0) begin
            lo_ph -= rsmp_pkg::UP_FACTOR;
            lo_idx++;
        end
        hi_idx += rsmp_pkg::STEP_INT;
        hi_ph  += rsmp_pkg::STEP_FRAC;
        if (hi_ph >= rsmp_pkg::UP_FACTOR) begin
            hi_ph -= rsmp_pkg::UP_FACTOR;
            hi_idx++;
        end
        return 1'b1;
    endfunction

    function automatic int rand_signed(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // receiver: stall pattern plus an on-request long hold
    int       hold_request = 0;
    int       hold_left = 0;
    int       mode_left = 0;
    int       rx_tick = 0;
    t_rx_mode rx_mode = RX_OPEN;

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        rx_tick++;
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN: begin
                    m_axis_tready <= 1'b1;
                end
                RX_COIN: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                end
                RX_SPARSE: begin
                    m_axis_tready <= ($urandom_range(0, 7) != 0);
                end
                default: begin
                    m_axis_tready <= (rx_tick % 5 == 0);
                end
            endcase
        end
    end

    t_stereo_out want;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pairs.size() == 0) begin
                $error("output item with nothing expected: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_pairs.pop_front();
                if (m_axis_tdata[15:0] !== want.left) begin
                    $error("left_out: expected %0d, got %0d",
                           want.left, $signed(m_axis_tdata[15:0]));
                    fail_count++;
                end
                if (m_axis_tdata[31:16] !== want.right) begin
                    $error("right_out: expected %0d, got %0d",
                           want.right, $signed(m_axis_tdata[31:16]));
                    fail_count++;
                end
                if (m_axis_tdata[47:32] !== want.peak) begin
                    $error("peak_level: expected %0d, got %0d",
                           want.peak, m_axis_tdata[47:32]);
                    fail_count++;
                end
            end
        end
    end

    // sender: bursts of random length with random gaps
    int burst_left = 0;

    task automatic send_item(input logic op, input logic [rsmp_pkg::HALF_W-1:0] cidx,
                             input rsmp_pkg::t_coef cval, input rsmp_pkg::t_sample l,
                             input rsmp_pkg::t_sample r);
        t_stereo_out res;
        int          gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, r, l, cval, cidx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == rsmp_pkg::OP_COEF) begin
            coef_mem[cidx] = cval;
        end else if (resample_pair(l, r, res)) begin
            expected_pairs.push_back(res);
        end
    endtask

    task automatic send_coef(input int idx, input int val);
        send_item(rsmp_pkg::OP_COEF, rsmp_pkg::HALF_W'(idx), rsmp_pkg::t_coef'(val),
                  rsmp_pkg::t_sample'($urandom), rsmp_pkg::t_sample'($urandom));
    endtask

    task automatic send_pair(input int l, input int r);
        send_item(rsmp_pkg::OP_SAMPLE, rsmp_pkg::HALF_W'($urandom),
                  rsmp_pkg::t_coef'($urandom), rsmp_pkg::t_sample'(l),
                  rsmp_pkg::t_sample'(r));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_pairs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_half_order(input int unsigned h);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rsmp_pkg::HALF_W'(h);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        order_cfg = h;
        restart_stream();
    endtask

    task automatic test_single_tap();
        send_coef(0, 1 << (rsmp_pkg::FRAC_BITS - 1));
        send_pair(1, 3);
        send_pair(-1, -3);
        send_pair(5, -5);
        send_pair(2, 0);
        send_coef(0, 1);
        send_pair(rsmp_pkg::SAT_MIN, rsmp_pkg::SAT_MAX);
        send_coef(0, 8388607);
        send_pair(1, -1);
        send_pair(0, 0);
        send_coef(0, -8388608);
        send_pair(-1, 1);
        send_coef(COEF_DEPTH - 1, rand_signed(1 << 12));
        send_coef(0, 1 << rsmp_pkg::FRAC_BITS);
        send_pair(1234, -4321);
        send_pair(-7, 32);
        wait_idle();
        set_half_order(0);
        send_pair(99, -99);
    endtask

    task automatic test_table_load();
        for (int i = 0; i < TABLE_LO; i++) begin
            send_coef(i, rand_signed(1 << 17));
        end
    endtask

    task automatic test_orders();
        int unsigned orders [8];
        int          amps [8];
        orders = '{1, 146, 147, 148, 294, 0, 200, TABLE_LO - 1};
        orders[5] = $urandom_range(2, TABLE_LO - 1);
        amps = '{256, 1024, 2048, 4096, 8192, 16384, 24576, 32767};
        foreach (orders[p]) begin
            wait_idle();
            set_half_order(orders[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == 40) begin
                    hold_request = LONG_HOLD;
                end
                if (p == 5 && n == 60) begin
                    wait_idle();
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_coef($urandom_range(0, TABLE_LO - 1),
                              ($urandom_range(0, 3) == 0) ? int'($urandom)
                                                          : rand_signed(1 << 17));
                end else if ($urandom_range(0, 15) == 0) begin
                    send_pair(0, 0);
                end else begin
                    send_pair(rand_signed(amps[p]), rand_signed(amps[p]));
                end
            end
        end
    endtask

    task automatic test_saturation();
        wait_idle();
        set_half_order(0);
        send_coef(0, -8388608);
        send_pair(rsmp_pkg::SAT_MAX, rsmp_pkg::SAT_MIN);
        send_pair(rsmp_pkg::SAT_MIN, rsmp_pkg::SAT_MAX);
        send_coef(0, 8388607);
        send_pair(rsmp_pkg::SAT_MAX, rsmp_pkg::SAT_MIN);
        send_pair(1000, -1000);
        send_coef(0, 1 << rsmp_pkg::FRAC_BITS);
        send_pair(rsmp_pkg::SAT_MIN, rsmp_pkg::SAT_MAX);
        wait_idle();
    endtask

    initial begin
        int drain_cycles;
        restart_stream();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_tap();
        test_table_load();
        test_orders();
        test_saturation();
        s_axis_tvalid <= 1'b0;
        drain_cycles = 0;
        while (expected_pairs.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_pairs.size() != 0) begin
            $error("%0d expected output items never arrived", expected_pairs.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
